>>> design/ifrt_pkg.sv
package ifrt_pkg;

	// Default geometry
	localparam int SLOTS_DEF  = 7;
	localparam int CHUNKS_DEF = 512;

	// Result status codes
	localparam logic [1:0] ST_WAIT = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_DROP = 2'd2;

	// Fragment descriptor request
	typedef struct packed {
		logic [15:0] frag_ident;
		logic [12:0] frag_offset;
		logic        more_fragments;
		logic [10:0] payload_len;
		logic [31:0] now_tick;
	} frag_req_t;

	// Result request
	typedef struct packed {
		logic [2:0]  slot_index;
		logic        new_entry;
		logic [11:0] byte_offset;
		logic [1:0]  status;
		logic [12:0] total_length;
	} res_req_t;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_PICK,
		S_CLEAR,
		S_MARK_RD,
		S_MARK_WR,
		S_UPDATE,
		S_CHK_RD,
		S_CHK_EVAL,
		S_FINISH
	} fsm_state_t;

endpackage

>>> design/ifrt_bitmap_mem.sv
module ifrt_bitmap_mem #(
	parameter int DEPTH = 112,
	parameter int AW    = 7
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [31:0]   wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [31:0]   rd_data
);

	logic [31:0] mem [DEPTH];

	// Single write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> design/ip_fragment_reassembly_tracker_core.sv
// Channel | Dir | Handshake          | Payload
// frag    | in  | frag_valid / stall | ifrt_pkg::frag_req_t
// res     | out | res_valid / stall  | ifrt_pkg::res_req_t
//
// One fragment at a time, in order: slot scan over all SLOTS, pick, bitmap
// clear of all WORDS on a new allocation, a read and a write per bitmap word
// touched by the fragment, update, a read and an evaluate per bitmap word
// checked up to the last chunk, finish and idle; a dropped fragment skips to finish.
// All bitmap accesses go through the single read / single write memory port.
// Reset clears the slot table; the bitmap is not reset and is cleared when
// a slot is allocated. A finished result waits in the output register while
// the next fragment is taken; a stalled result holds the sequencer in FINISH.
module ip_fragment_reassembly_tracker_core #(
	parameter int SLOTS  = ifrt_pkg::SLOTS_DEF,
	parameter int CHUNKS = ifrt_pkg::CHUNKS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                frag_valid,
	output logic                frag_stall,
	input  ifrt_pkg::frag_req_t frag,
	output logic                res_valid,
	input  logic                res_stall,
	output ifrt_pkg::res_req_t  res
);

	localparam int SW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int WORDS     = (CHUNKS + 31) / 32;
	localparam int WW        = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int DEPTH     = SLOTS * WORDS;
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CHW_RAW   = $clog2(CHUNKS + 1);
	localparam int CHW       = (CHW_RAW > 6) ? CHW_RAW : 6;
	localparam int BUF_BYTES = 8 * CHUNKS;
	localparam int TW        = $clog2(BUF_BYTES + 1);

	ifrt_pkg::fsm_state_t state_q, state_d;

	// Slot table
	logic          valid_q     [SLOTS];
	logic [15:0]   ident_q     [SLOTS];
	logic [31:0]   stamp_q     [SLOTS];
	logic          last_seen_q [SLOTS];
	logic [CHW-1:0] last_chunk_q [SLOTS];
	logic [TW-1:0] total_q     [SLOTS];

	// Working registers
	ifrt_pkg::frag_req_t req_q;
	logic           drop_q;
	logic [CHW-1:0] lo_q, hi_q;
	logic [TW-1:0]  end_q;
	logic [SW-1:0]  scan_i_q;
	logic           match_found_q, free_found_q;
	logic [SW-1:0]  match_q, free_q, min_q;
	logic [31:0]    min_stamp_q;
	logic           m_ls_q;
	logic [TW-1:0]  m_tot_q;
	logic [CHW-1:0] m_lc_q;
	logic [SW-1:0]  slot_q;
	logic           fresh_q;
	logic           ls_q;
	logic [TW-1:0]  tot_q;
	logic [CHW-1:0] lc_q;
	logic [WW-1:0]  word_q;
	logic           complete_q;
	logic           res_valid_q;
	ifrt_pkg::res_req_t res_q;

	// Bitmap memory port
	logic          mem_we, mem_re;
	logic [31:0]   mem_wdata, mem_rdata;
	logic [AW-1:0] mem_addr;

	// Input decode
	logic [16:0]    end_byte;
	logic [11:0]    n_chunks;
	logic           drop_in;
	logic           accept;

	assign end_byte = {1'b0, frag.frag_offset, 3'b000} + 17'(frag.payload_len);
	assign n_chunks = ({1'b0, frag.payload_len} + 12'd7) >> 3;
	assign drop_in  = (14'(frag.frag_offset) >= 14'(CHUNKS)) ||
	                  (end_byte > 17'(BUF_BYTES));
	assign frag_stall = (state_q != ifrt_pkg::S_IDLE);
	assign accept     = frag_valid && !frag_stall;

	// Word range, masks and end-of-loop conditions
	logic [WW-1:0]  wlo, whi, lcw;
	logic [CHW:0]   wbase;
	logic [5:0]     lo_b, hi_b;
	logic [32:0]    mask33, chk33;
	logic [31:0]    mark_mask, chk_mask;
	logic           chk_pass;
	logic [TW:0]    end_r;
	logic [CHW-1:0] lc_new;
	logic           eff_ls;
	logic [TW-1:0]  eff_tot;
	logic           scan_last, clear_last, mark_last, chk_last, res_free;
	logic           has_data;

	assign wlo   = WW'(lo_q >> 5);
	assign whi   = WW'((hi_q - CHW'(1)) >> 5);
	assign lcw   = WW'(lc_q >> 5);
	assign wbase = (CHW+1)'({word_q, 5'b00000});
	assign lo_b  = ({1'b0, lo_q} > wbase) ? 6'({1'b0, lo_q} - wbase) : 6'd0;
	assign hi_b  = ({1'b0, hi_q} >= wbase + (CHW+1)'(32)) ? 6'd32
	                                                     : 6'({1'b0, hi_q} - wbase);
	assign mask33    = ((33'd1 << hi_b) - 33'd1) & ~((33'd1 << lo_b) - 33'd1);
	assign mark_mask = mask33[31:0];
	assign chk33     = (33'd2 << lc_q[4:0]) - 33'd1;
	assign chk_mask  = (word_q == lcw) ? chk33[31:0] : 32'hffff_ffff;
	assign chk_pass  = &(mem_rdata | ~chk_mask);

	assign end_r   = (TW+1)'(end_q) + (TW+1)'(7);
	assign lc_new  = (end_q != '0) ? CHW'(end_r >> 3) - CHW'(1) : '0;
	assign eff_ls  = req_q.more_fragments ? ls_q : 1'b1;
	assign eff_tot = req_q.more_fragments ? tot_q : end_q;

	assign scan_last  = (scan_i_q == SW'(SLOTS - 1));
	assign clear_last = (word_q == WW'(WORDS - 1));
	assign mark_last  = (word_q == whi);
	assign chk_last   = (word_q == lcw);
	assign res_free   = !res_valid_q || !res_stall;
	assign has_data   = (req_q.payload_len != '0);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ifrt_pkg::S_IDLE: begin
				if (accept) begin
					state_d = drop_in ? ifrt_pkg::S_FINISH : ifrt_pkg::S_SCAN;
				end
			end
			ifrt_pkg::S_SCAN: begin
				if (scan_last) begin
					state_d = ifrt_pkg::S_PICK;
				end
			end
			ifrt_pkg::S_PICK: begin
				if (!match_found_q) begin
					state_d = ifrt_pkg::S_CLEAR;
				end else begin
					state_d = has_data ? ifrt_pkg::S_MARK_RD : ifrt_pkg::S_UPDATE;
				end
			end
			ifrt_pkg::S_CLEAR: begin
				if (clear_last) begin
					state_d = has_data ? ifrt_pkg::S_MARK_RD : ifrt_pkg::S_UPDATE;
				end
			end
			ifrt_pkg::S_MARK_RD: state_d = ifrt_pkg::S_MARK_WR;
			ifrt_pkg::S_MARK_WR: begin
				state_d = mark_last ? ifrt_pkg::S_UPDATE : ifrt_pkg::S_MARK_RD;
			end
			ifrt_pkg::S_UPDATE: begin
				state_d = (eff_ls && eff_tot != '0) ? ifrt_pkg::S_CHK_RD
				                                     : ifrt_pkg::S_FINISH;
			end
			ifrt_pkg::S_CHK_RD: state_d = ifrt_pkg::S_CHK_EVAL;
			ifrt_pkg::S_CHK_EVAL: begin
				state_d = (!chk_pass || chk_last) ? ifrt_pkg::S_FINISH
				                                  : ifrt_pkg::S_CHK_RD;
			end
			ifrt_pkg::S_FINISH: begin
				if (res_free) begin
					state_d = ifrt_pkg::S_IDLE;
				end
			end
			default: state_d = ifrt_pkg::S_IDLE;
		endcase
	end

	// Memory control
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_wdata = '0;
		unique case (state_q)
			ifrt_pkg::S_CLEAR: begin
				mem_we = 1'b1;
			end
			ifrt_pkg::S_MARK_WR: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata | mark_mask;
			end
			ifrt_pkg::S_MARK_RD, ifrt_pkg::S_CHK_RD: begin
				mem_re = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign mem_addr = AW'(slot_q) * AW'(WORDS) + AW'(word_q);

	ifrt_bitmap_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_bitmap (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_addr),
		.wr_data (mem_wdata),
		.rd_en   (mem_re),
		.rd_addr (mem_addr),
		.rd_data (mem_rdata)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ifrt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Working datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ifrt_pkg::S_IDLE: begin
				if (accept) begin
					req_q         <= frag;
					drop_q        <= drop_in;
					lo_q          <= CHW'(frag.frag_offset);
					hi_q          <= CHW'(frag.frag_offset) + CHW'(n_chunks);
					end_q         <= TW'(end_byte);
					scan_i_q      <= '0;
					match_found_q <= 1'b0;
					free_found_q  <= 1'b0;
				end
			end
			ifrt_pkg::S_SCAN: begin
				// one slot per cycle: match, first free, oldest stamp
				if (!match_found_q && valid_q[scan_i_q] &&
				    ident_q[scan_i_q] == req_q.frag_ident) begin
					match_found_q <= 1'b1;
					match_q       <= scan_i_q;
					m_ls_q        <= last_seen_q[scan_i_q];
					m_tot_q       <= total_q[scan_i_q];
					m_lc_q        <= last_chunk_q[scan_i_q];
				end
				if (!free_found_q && !valid_q[scan_i_q]) begin
					free_found_q <= 1'b1;
					free_q       <= scan_i_q;
				end
				if (scan_i_q == '0 || stamp_q[scan_i_q] < min_stamp_q) begin
					min_q       <= scan_i_q;
					min_stamp_q <= stamp_q[scan_i_q];
				end
				scan_i_q <= scan_i_q + SW'(1);
			end
			ifrt_pkg::S_PICK: begin
				if (match_found_q) begin
					slot_q  <= match_q;
					fresh_q <= 1'b0;
					ls_q    <= m_ls_q;
					tot_q   <= m_tot_q;
					lc_q    <= m_lc_q;
					word_q  <= wlo;
				end else begin
					slot_q  <= free_found_q ? free_q : min_q;
					fresh_q <= 1'b1;
					ls_q    <= 1'b0;
					tot_q   <= '0;
					lc_q    <= '0;
					word_q  <= '0;
				end
			end
			ifrt_pkg::S_CLEAR: begin
				word_q <= clear_last ? wlo : word_q + WW'(1);
			end
			ifrt_pkg::S_MARK_WR: begin
				word_q <= word_q + WW'(1);
			end
			ifrt_pkg::S_UPDATE: begin
				// last fragment sets the length
				if (!req_q.more_fragments) begin
					ls_q  <= 1'b1;
					tot_q <= end_q;
					lc_q  <= lc_new;
				end
				word_q     <= '0;
				complete_q <= eff_ls;
			end
			ifrt_pkg::S_CHK_EVAL: begin
				if (!chk_pass) begin
					complete_q <= 1'b0;
				end else if (chk_last) begin
					complete_q <= 1'b1;
				end else begin
					word_q <= word_q + WW'(1);
				end
			end
			default: begin
				word_q <= word_q;
			end
		endcase
	end

	// Slot table write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				valid_q[i]      <= 1'b0;
				ident_q[i]      <= '0;
				stamp_q[i]      <= '0;
				last_seen_q[i]  <= 1'b0;
				last_chunk_q[i] <= '0;
				total_q[i]      <= '0;
			end
		end else if (state_q == ifrt_pkg::S_FINISH && res_free && !drop_q) begin
			if (complete_q) begin
				valid_q[slot_q]      <= 1'b0;
				ident_q[slot_q]      <= '0;
				stamp_q[slot_q]      <= '0;
				last_seen_q[slot_q]  <= 1'b0;
				last_chunk_q[slot_q] <= '0;
				total_q[slot_q]      <= '0;
			end else begin
				valid_q[slot_q]      <= 1'b1;
				ident_q[slot_q]      <= req_q.frag_ident;
				stamp_q[slot_q]      <= req_q.now_tick;
				last_seen_q[slot_q]  <= ls_q;
				last_chunk_q[slot_q] <= lc_q;
				total_q[slot_q]      <= tot_q;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ifrt_pkg::S_FINISH && res_free) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ifrt_pkg::S_FINISH && res_free) begin
			if (drop_q) begin
				res_q <= '{slot_index: '0, new_entry: 1'b0, byte_offset: '0,
				           status: ifrt_pkg::ST_DROP, total_length: '0};
			end else begin
				res_q.slot_index   <= 3'(slot_q);
				res_q.new_entry    <= fresh_q;
				res_q.byte_offset  <= {req_q.frag_offset[8:0], 3'b000};
				res_q.status       <= complete_q ? ifrt_pkg::ST_DONE : ifrt_pkg::ST_WAIT;
				res_q.total_length <= complete_q ? 13'(tot_q) : 13'd0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Checks
	a_res_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q == ifrt_pkg::S_FINISH))
		else $error("result raised outside FINISH");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ifrt_pkg::S_CLEAR || state_q == ifrt_pkg::S_MARK_WR))
		else $error("bitmap write outside clear or mark");

	a_drop_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == ifrt_pkg::ST_DROP) |->
		(res.total_length == '0 && !res.new_entry && res.slot_index == '0))
		else $error("dropped result carries data");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> frag_stall)
		else $error("request accepted without going busy");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int NSLOT = 7;
	localparam int NCHUNK = 512;
	localparam int RANDOM_FRAGS = 1400;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n;
	logic frag_valid;
	logic frag_stall;
	ifrt_pkg::frag_req_t frag;
	logic res_valid;
	logic res_stall;
	ifrt_pkg::res_req_t res;

	ip_fragment_reassembly_tracker_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.frag_valid(frag_valid),
		.frag_stall(frag_stall),
		.frag(frag),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	// Shadow slot table
	bit          sh_valid [NSLOT];
	logic [15:0] sh_ident [NSLOT];
	logic [31:0] sh_stamp [NSLOT];
	bit          sh_last [NSLOT];
	int          sh_lastchunk [NSLOT];
	int          sh_total [NSLOT];
	bit          sh_chunks [NSLOT][NCHUNK];

	ifrt_pkg::res_req_t pending_results[$];
	int errors;
	int done_count, drop_count;
	longint cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void free_slot(int s);
		sh_valid[s] = 0;
		sh_ident[s] = '0;
		sh_stamp[s] = '0;
		sh_last[s] = 0;
		sh_lastchunk[s] = 0;
		sh_total[s] = 0;
		for (int c = 0; c < NCHUNK; c++) sh_chunks[s][c] = 0;
	endfunction

	// Predict the result of one fragment and update the shadow table
	function automatic ifrt_pkg::res_req_t track_fragment(ifrt_pkg::frag_req_t f);
		ifrt_pkg::res_req_t r;
		int slot, n, t;
		bit found, fresh, complete;
		r = '0;
		slot = 0;
		found = 0;
		fresh = 0;
		if (f.frag_offset >= NCHUNK || int'(f.frag_offset) * 8 + int'(f.payload_len) > NCHUNK * 8) begin
			r.status = ifrt_pkg::ST_DROP;
			return r;
		end
		for (int s = 0; s < NSLOT && !found; s++)
			if (sh_valid[s] && sh_ident[s] == f.frag_ident) begin
				slot = s;
				found = 1;
			end
		if (!found) begin
			for (int s = 0; s < NSLOT && !found; s++)
				if (!sh_valid[s]) begin
					slot = s;
					found = 1;
				end
			if (!found) begin
				slot = 0;
				for (int s = 1; s < NSLOT; s++)
					if (sh_stamp[s] < sh_stamp[slot]) slot = s;
			end
			free_slot(slot);
			sh_valid[slot] = 1;
			sh_ident[slot] = f.frag_ident;
			fresh = 1;
		end
		n = (int'(f.payload_len) + 7) / 8;
		for (int c = f.frag_offset; c < int'(f.frag_offset) + n; c++)
			if (c < NCHUNK) sh_chunks[slot][c] = 1;
		if (!f.more_fragments) begin
			t = int'(f.frag_offset) * 8 + int'(f.payload_len);
			sh_last[slot] = 1;
			sh_total[slot] = t;
			sh_lastchunk[slot] = t ? (t + 7) / 8 - 1 : 0;
		end
		sh_stamp[slot] = f.now_tick;
		complete = sh_last[slot];
		if (complete && sh_total[slot] != 0)
			for (int c = 0; c <= sh_lastchunk[slot] && c < NCHUNK; c++)
				if (!sh_chunks[slot][c]) begin
					complete = 0;
					break;
				end
		r.slot_index = slot[2:0];
		r.new_entry = fresh;
		r.byte_offset = 12'(int'(f.frag_offset) * 8);
		if (complete) begin
			r.status = ifrt_pkg::ST_DONE;
			r.total_length = 13'(sh_total[slot]);
			free_slot(slot);
		end else begin
			r.status = ifrt_pkg::ST_WAIT;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Result checker and stall generator
	always @(posedge clk) begin
		ifrt_pkg::res_req_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = pending_results.pop_front();
				if (res.slot_index !== want.slot_index)
					report_mismatch("slot_index", res.slot_index, want.slot_index);
				if (res.new_entry !== want.new_entry)
					report_mismatch("new_entry", res.new_entry, want.new_entry);
				if (res.byte_offset !== want.byte_offset)
					report_mismatch("byte_offset", res.byte_offset, want.byte_offset);
				if (res.status !== want.status)
					report_mismatch("status", res.status, want.status);
				if (res.total_length !== want.total_length)
					report_mismatch("total_length", res.total_length, want.total_length);
				if (res.status == ifrt_pkg::ST_DONE) done_count++;
				if (res.status == ifrt_pkg::ST_DROP) drop_count++;
			end
		end
	end

	int stall_run;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_run = 0;
		end else if (stall_run > 0) begin
			stall_run--;
			res_stall <= 1'b1;
		end else if (($urandom % 100) < ((cycles / 20000) % 2 ? 0 : 20)) begin
			stall_run = ($urandom % 10 == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// Cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	// Push one request and wait for acceptance
	task automatic send_fragment(ifrt_pkg::frag_req_t f);
		frag <= f;
		frag_valid <= 1'b1;
		@(posedge clk);
		while (frag_stall) @(posedge clk);
		pending_results.push_back(track_fragment(f));
	endtask

	task automatic idle_gap();
		int g;
		if ($urandom % 3 == 0) begin
			g = ($urandom % 12 == 0) ? $urandom_range(30, 150) : $urandom_range(1, 4);
			frag_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	function automatic ifrt_pkg::frag_req_t make_frag(int id, int off, bit mf, int len, int tick);
		ifrt_pkg::frag_req_t f;
		f.frag_ident = 16'(id);
		f.frag_offset = 13'(off);
		f.more_fragments = mf;
		f.payload_len = 11'(len);
		f.now_tick = 32'(tick);
		return f;
	endfunction

	// Directed rows: ident, offset, mf, len, tick; expected status when obvious, -1 otherwise
	typedef struct {
		int id; int off; bit mf; int len; longint tick; int want_status;
	} row_t;

	row_t rows[] = '{
		'{16'h0001, 0, 0, 0, 1, 1},          // empty datagram completes at once
		'{16'h0002, 512, 0, 8, 2, 2},        // offset past buffer
		'{16'h0003, 8191, 1, 2047, 3, 2},    // extreme offset and length
		'{16'h0004, 511, 0, 9, 4, 2},        // runs one byte past the end
		'{16'h0005, 511, 0, 8, 5, 0},        // last chunk of the buffer, hole below
		'{16'hffff, 0, 1, 2040, 6, 0},       // long first fragment
		'{16'hffff, 256, 0, 0, 7, 0},        // zero-length last fragment
		'{16'hffff, 255, 1, 8, 8, -1},       // fills the hole
		'{16'h0010, 4, 0, 1, 9, 0},          // last first
		'{16'h0010, 4, 0, 16, 10, 0},        // repeated last overrides length
		'{16'h0010, 0, 1, 32, 11, -1},       // completes
		'{16'h0020, 0, 1, 8, 32'hffffffff, 0},
		'{16'h0021, 0, 1, 8, 20, 0},
		'{16'h0022, 0, 1, 8, 21, 0},
		'{16'h0023, 0, 1, 8, 22, 0},
		'{16'h0024, 0, 1, 8, 23, 0},
		'{16'h0025, 0, 1, 8, 24, 0},
		'{16'h0026, 0, 1, 8, 0, -1},         // table full, evicts least recent
		'{16'h0027, 0, 1, 8, 0, -1},
		'{16'h0028, 64, 0, 1, 32'h7fffffff, -1},
		'{16'h0000, 0, 0, 2047, 30, 1}       // single whole datagram
	};

	initial begin
		ifrt_pkg::frag_req_t f;
		int ids[8];
		int id, off, len, kind, base;
		errors = 0;
		cycles = 0;
		done_count = 0;
		drop_count = 0;
		arst_n = 1'b0;
		frag_valid = 1'b0;
		frag = '0;
		for (int s = 0; s < NSLOT; s++) free_slot(s);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		foreach (rows[i]) begin
			f = make_frag(rows[i].id, rows[i].off, rows[i].mf, rows[i].len, 32'(rows[i].tick));
			send_fragment(f);
			if (rows[i].want_status >= 0 &&
			    pending_results[$].status != 2'(rows[i].want_status))
				report_mismatch("directed status", pending_results[$].status,
					rows[i].want_status);
			idle_gap();
		end

		// Drain before the random part
		frag_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);

		// Random part: mostly well-formed datagrams split into fragments
		for (int k = 0; k < 8; k++) ids[k] = $urandom;
		base = 100;
		for (int n = 0; n < RANDOM_FRAGS; ) begin
			kind = $urandom % 10;
			if (kind < 7) begin
				// datagram of a few fragments, shuffled order, sometimes with one deleted
				int pieces, total8;
				ifrt_pkg::frag_req_t q[$];
				id = ($urandom % 4 == 0) ? $urandom : ids[$urandom % 8];
				pieces = $urandom_range(1, 4);
				total8 = ($urandom % 8 == 0) ? $urandom_range(100, 511) : $urandom_range(1, 24);
				off = 0;
				for (int p = 0; p < pieces; p++) begin
					int span;
					span = (p == pieces - 1) ? total8 - off
						: $urandom_range(0, (total8 - off) / 2);
					len = span * 8;
					if (p == pieces - 1) begin
						len = span * 8 - (($urandom % 2) ? $urandom_range(0, 7) : 0);
						if (len < 0) len = 0;
						if (len > 2047) len = 2047;
					end
					if (len > 2047) len = 2040;
					q.push_back(make_frag(id, off, p != pieces - 1, len, base + $urandom_range(0, 50)));
					off += len / 8;
				end
				q.shuffle();
				if ($urandom % 6 == 0) q.delete($urandom % q.size());
				foreach (q[j]) begin
					send_fragment(q[j]);
					n++;
					idle_gap();
				end
			end else begin
				// noise: any field values, biased toward the buffer edge
				f = ifrt_pkg::frag_req_t'(73'({$urandom, $urandom, $urandom}));
				if ($urandom % 2) f.frag_offset = 13'($urandom_range(0, 520));
				if ($urandom % 3 == 0) f.frag_ident = 16'(ids[$urandom % 8]);
				send_fragment(f);
				n++;
				idle_gap();
			end
			base += $urandom_range(0, 40);
			// pause until the block has answered everything
			if (n % 300 < 5 && $urandom % 2) begin
				frag_valid <= 1'b0;
				while (pending_results.size() != 0) @(posedge clk);
			end
		end
		frag_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("Covered %0d random fragments plus the directed table:", RANDOM_FRAGS);
		$display("  %0d datagrams completed, %0d fragments dropped", done_count, drop_count);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

>>> files.f
design/ifrt_pkg.sv
design/ifrt_bitmap_mem.sv
design/ip_fragment_reassembly_tracker_core.sv
sim/tb.sv
